// ===== sv/badm_pkg.sv =====
package badm_pkg;

   // Default sizes, in bytes
   localparam int WORK_RAM_BYTES_DEF = 131072;
   localparam int SAVE_RAM_BYTES_DEF = 32768;
   localparam int ROM_MAX_BYTES_DEF  = 1048576;

   localparam int ADDR_W = 24;
   localparam int DATA_W = 16;

   // Access modes
   localparam logic [2:0] MODE_RD_BYTE  = 3'd0;
   localparam logic [2:0] MODE_WR_BYTE  = 3'd1;
   localparam logic [2:0] MODE_RD_WORD  = 3'd2;
   localparam logic [2:0] MODE_WR_WORD  = 3'd3;
   localparam logic [2:0] MODE_LOAD_ROM = 3'd4;

   // Regions
   localparam logic [1:0] REGION_WORK = 2'd0;
   localparam logic [1:0] REGION_HW   = 2'd1;
   localparam logic [1:0] REGION_SAVE = 2'd2;
   localparam logic [1:0] REGION_CART = 2'd3;

   // Byte operation kinds
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;

   // Byte targets; ONES reads back FF
   localparam logic [1:0] TGT_WORK = 2'd0;
   localparam logic [1:0] TGT_SAVE = 2'd1;
   localparam logic [1:0] TGT_ROM  = 2'd2;
   localparam logic [1:0] TGT_ONES = 2'd3;

   // Control register indexes
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_ROM_PRESENT   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROM_SIZE_LOG2 = 1'd1;

   // Op queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;

   typedef struct packed {
      logic [2:0]        mode;
      logic [ADDR_W-1:0] bus_address;
      logic [DATA_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [1:0]        region;
   } rsp_type;

   // One byte access
   typedef struct packed {
      logic [1:0]        kind;
      logic [1:0]        target;
      logic [ADDR_W-1:0] index;
      logic [7:0]        wdata;
      logic              hi;
      logic              last;
      logic [1:0]        region;
   } op_type;

endpackage

// ===== sv/badm_front.sv =====
module badm_front #(
   parameter int WORK_RAM_BYTES = badm_pkg::WORK_RAM_BYTES_DEF,
   parameter int SAVE_RAM_BYTES = badm_pkg::SAVE_RAM_BYTES_DEF,
   parameter int ROM_MAX_BYTES  = badm_pkg::ROM_MAX_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               clearing,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  badm_pkg::req_type                  req_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [badm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [badm_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                               op_valid,
   input  logic                               op_ready,
   output badm_pkg::op_type                   op_data
);

   localparam logic [17:0] WORK_LIM = 18'(WORK_RAM_BYTES);
   localparam logic [15:0] SAVE_MASK = 16'(SAVE_RAM_BYTES - 1);
   localparam logic [24:0] ROM_LIM = 25'(ROM_MAX_BYTES);

   logic              rom_present_ff, rom_present_in;
   logic [4:0]        rom_log2_ff, rom_log2_in;
   logic              pend_ff, pend_in;
   logic              phase_ff, phase_in;
   logic [1:0]        region_ff, region_in;
   badm_pkg::req_type req_ff;

   logic [23:0] baddr;
   logic [7:0]  bank;
   logic [15:0] off;
   logic        low_bank, wram_bank;
   logic [1:0]  region;
   logic [16:0] widx;
   logic        wram_ok;
   logic [15:0] sidx;
   logic [23:0] rmask, ridx;
   logic        rom_ok;
   logic [1:0]  target;
   logic [23:0] index;
   logic        is_word, push;

   // Config registers, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      rom_present_in = rom_present_ff;
      rom_log2_in = rom_log2_ff;
      if (csr_valid) begin
         unique case (csr_index)
            badm_pkg::CSR_ROM_PRESENT:   rom_present_in = csr_data[0];
            badm_pkg::CSR_ROM_SIZE_LOG2: rom_log2_in = csr_data;
            default: ;
         endcase
      end
   end

   // Byte address of the current phase, word wraps at 24 bits
   assign baddr = phase_ff ? (req_ff.bus_address + 24'd1) : req_ff.bus_address;
   assign bank = baddr[23:16];
   assign off = baddr[15:0];
   assign low_bank = ~bank[6];
   assign wram_bank = (bank == 8'h7E) || (bank == 8'h7F);

   // Region decode
   always_comb begin
      if (low_bank) begin
         if (off[15])
            region = badm_pkg::REGION_CART;
         else if (off[14:13] == 2'b11)
            region = badm_pkg::REGION_SAVE;
         else if (off[14:13] == 2'b00)
            region = badm_pkg::REGION_WORK;
         else
            region = badm_pkg::REGION_HW;
      end else if (wram_bank) begin
         region = badm_pkg::REGION_WORK;
      end else begin
         region = badm_pkg::REGION_CART;
      end
   end

   // Index and range checks per store
   assign widx = low_bank ? {4'd0, off[12:0]} : {bank[0], off};
   assign wram_ok = {1'b0, widx} < WORK_LIM;
   assign sidx = {3'd0, off[12:0]} & SAVE_MASK;
   assign rmask = (rom_log2_ff >= 5'd24) ? 24'hFFFFFF
                                         : ((24'd1 << rom_log2_ff) - 24'd1);
   assign ridx = baddr & rmask;
   assign rom_ok = rom_present_ff && ({1'b0, ridx} < ROM_LIM);

   always_comb begin
      target = badm_pkg::TGT_ONES;
      index = '0;
      unique case (region)
         badm_pkg::REGION_WORK: begin
            if (wram_ok) begin
               target = badm_pkg::TGT_WORK;
               index = {7'd0, widx};
            end
         end
         badm_pkg::REGION_SAVE: begin
            target = badm_pkg::TGT_SAVE;
            index = {8'd0, sidx};
         end
         badm_pkg::REGION_CART: begin
            if (rom_ok) begin
               target = badm_pkg::TGT_ROM;
               index = ridx;
            end
         end
         default: ;
      endcase
   end

   assign is_word = (req_ff.mode == badm_pkg::MODE_RD_WORD) ||
                    (req_ff.mode == badm_pkg::MODE_WR_WORD);

   // Build the byte op for this phase
   always_comb begin
      op_data.kind = badm_pkg::KIND_NONE;
      op_data.target = target;
      op_data.index = index;
      op_data.wdata = phase_ff ? req_ff.write_data[15:8] : req_ff.write_data[7:0];
      op_data.hi = phase_ff;
      op_data.last = phase_ff || !is_word;
      op_data.region = phase_ff ? region_ff : region;
      unique case (req_ff.mode)
         badm_pkg::MODE_RD_BYTE, badm_pkg::MODE_RD_WORD:
            op_data.kind = badm_pkg::KIND_READ;
         badm_pkg::MODE_WR_BYTE, badm_pkg::MODE_WR_WORD: begin
            if (target == badm_pkg::TGT_WORK || target == badm_pkg::TGT_SAVE)
               op_data.kind = badm_pkg::KIND_WRITE;
         end
         badm_pkg::MODE_LOAD_ROM: begin
            op_data.region = badm_pkg::REGION_CART;
            op_data.target = badm_pkg::TGT_ROM;
            op_data.index = req_ff.bus_address;
            if ({1'b0, req_ff.bus_address} < ROM_LIM)
               op_data.kind = badm_pkg::KIND_WRITE;
         end
         default: ;
      endcase
   end

   assign op_valid = pend_ff;
   assign push = pend_ff && op_ready;
   assign req_ready = !pend_ff && !clearing;

   // Request sequencing
   always_comb begin
      pend_in = pend_ff;
      phase_in = phase_ff;
      region_in = region_ff;
      if (req_valid && req_ready) begin
         pend_in = 1'b1;
         phase_in = 1'b0;
      end else if (push) begin
         region_in = region;
         if (is_word && !phase_ff)
            phase_in = 1'b1;
         else
            pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_present_ff <= 1'b0;
         rom_log2_ff <= '0;
         pend_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         rom_present_ff <= rom_present_in;
         rom_log2_ff <= rom_log2_in;
         pend_ff <= pend_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      region_ff <= region_in;
      if (req_valid && req_ready)
         req_ff <= req_payload;
   end

endmodule

// ===== sv/badm_queue.sv =====
module badm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  badm_pkg::op_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output badm_pkg::op_type pop_data
);

   localparam int CNT_W = badm_pkg::QUEUE_PTR_W + 1;
   localparam logic [CNT_W-1:0] FULL = CNT_W'(badm_pkg::QUEUE_DEPTH);

   badm_pkg::op_type                  entry_ff [badm_pkg::QUEUE_DEPTH];
   logic [badm_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [badm_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic                              do_push, do_pop;

   assign push_ready = cnt_ff != FULL;
   assign pop_valid = cnt_ff != '0;
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop)
         cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push)
         cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== sv/badm_back.sv =====
module badm_back #(
   parameter int WORK_RAM_BYTES = badm_pkg::WORK_RAM_BYTES_DEF,
   parameter int SAVE_RAM_BYTES = badm_pkg::SAVE_RAM_BYTES_DEF,
   parameter int ROM_MAX_BYTES  = badm_pkg::ROM_MAX_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   output logic              clearing,
   input  logic              op_valid,
   output logic              op_ready,
   input  badm_pkg::op_type  op_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output badm_pkg::rsp_type rsp_payload
);

   localparam int WAW = $clog2(WORK_RAM_BYTES);
   localparam int SAW = $clog2(SAVE_RAM_BYTES);
   localparam int RAW = $clog2(ROM_MAX_BYTES);
   localparam int CLR_N = (WORK_RAM_BYTES > SAVE_RAM_BYTES) ? WORK_RAM_BYTES
                                                             : SAVE_RAM_BYTES;
   localparam int CW = $clog2(CLR_N);
   localparam logic [CW:0] WORK_LIM = (CW+1)'(WORK_RAM_BYTES);
   localparam logic [CW:0] SAVE_LIM = (CW+1)'(SAVE_RAM_BYTES);
   localparam logic [CW-1:0] CLR_LAST = CW'(CLR_N - 1);

   logic [7:0] work_mem [WORK_RAM_BYTES];
   logic [7:0] save_mem [SAVE_RAM_BYTES];
   logic [7:0] rom_mem  [ROM_MAX_BYTES];
   logic [7:0] work_q_ff, save_q_ff, rom_q_ff;

   logic              clr_ff, clr_in;
   logic [CW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic              s1_valid_ff, s1_valid_in;
   badm_pkg::op_type  s1_ff;
   logic [7:0]        lo_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   badm_pkg::rsp_type rsp_ff;

   logic       out_free, s1_go, pop;
   logic       is_rd, is_wr;
   logic       work_we, save_we, rom_we;
   logic [WAW-1:0] work_wa;
   logic [SAW-1:0] save_wa;
   logic [7:0] clr_wd;
   logic [7:0] byte_val;

   assign clearing = clr_ff;

   // Pipeline control: issue, then data, then response register
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s1_go = s1_valid_ff && (!s1_ff.last || out_free);
   assign pop = !clr_ff && op_valid && (!s1_valid_ff || s1_go);
   assign op_ready = pop;
   assign is_rd = pop && (op_data.kind == badm_pkg::KIND_READ);
   assign is_wr = pop && (op_data.kind == badm_pkg::KIND_WRITE);

   // Work and save write ports, shared with the clearing sweep
   assign clr_wd = clr_ff ? 8'd0 : op_data.wdata;
   assign work_we = clr_ff ? ({1'b0, clr_cnt_ff} < WORK_LIM)
                           : (is_wr && op_data.target == badm_pkg::TGT_WORK);
   assign save_we = clr_ff ? ({1'b0, clr_cnt_ff} < SAVE_LIM)
                           : (is_wr && op_data.target == badm_pkg::TGT_SAVE);
   assign rom_we = is_wr && op_data.target == badm_pkg::TGT_ROM;
   assign work_wa = clr_ff ? clr_cnt_ff[WAW-1:0] : op_data.index[WAW-1:0];
   assign save_wa = clr_ff ? clr_cnt_ff[SAW-1:0] : op_data.index[SAW-1:0];

   always_ff @(posedge clock) begin
      if (work_we)
         work_mem[work_wa] <= clr_wd;
      if (is_rd && op_data.target == badm_pkg::TGT_WORK)
         work_q_ff <= work_mem[op_data.index[WAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (save_we)
         save_mem[save_wa] <= clr_wd;
      if (is_rd && op_data.target == badm_pkg::TGT_SAVE)
         save_q_ff <= save_mem[op_data.index[SAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (rom_we)
         rom_mem[op_data.index[RAW-1:0]] <= op_data.wdata;
      if (is_rd && op_data.target == badm_pkg::TGT_ROM)
         rom_q_ff <= rom_mem[op_data.index[RAW-1:0]];
   end

   // Byte read result; writes and no-ops give zero
   always_comb begin
      byte_val = 8'd0;
      if (s1_ff.kind == badm_pkg::KIND_READ) begin
         unique case (s1_ff.target)
            badm_pkg::TGT_WORK: byte_val = work_q_ff;
            badm_pkg::TGT_SAVE: byte_val = save_q_ff;
            badm_pkg::TGT_ROM:  byte_val = rom_q_ff;
            default:            byte_val = 8'hFF;
         endcase
      end
   end

   // Clearing sweep and stage valids
   always_comb begin
      clr_in = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == CLR_LAST)
            clr_in = 1'b0;
      end
      s1_valid_in = pop ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && s1_ff.last)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= 1'b1;
         clr_cnt_ff <= '0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (pop)
         s1_ff <= op_data;
      if (s1_go && !s1_ff.last)
         lo_ff <= byte_val;
      if (s1_go && s1_ff.last) begin
         rsp_ff.read_data <= s1_ff.hi ? {byte_val, lo_ff} : {8'd0, byte_val};
         rsp_ff.region <= s1_ff.region;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== sv/bus_address_decoder_memory.sv =====
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  badm_pkg::req_type (mode, address, data)
// rsp      out        rsp_valid/rsp_ready  badm_pkg::rsp_type (read data, region)
// csr      in         csr_valid/csr_ready  csr_index, csr_data (always ready)
//
// The front decodes one byte per cycle into the op queue while the queue has
// room, a word request as two byte ops, and the single-port stores in the back
// take one byte access per cycle unless a stalled response holds them; the
// read byte passes the store read and stage registers into the response register.
// After reset, work and save RAM are zeroed by a sweep over max(WORK_RAM_BYTES,
// SAVE_RAM_BYTES) addresses (131072 by default) while req_ready is held low.
// A stalled response holds the back; the queue lets the front keep decoding.
module bus_address_decoder_memory #(
   parameter int WORK_RAM_BYTES = badm_pkg::WORK_RAM_BYTES_DEF,
   parameter int SAVE_RAM_BYTES = badm_pkg::SAVE_RAM_BYTES_DEF,
   parameter int ROM_MAX_BYTES  = badm_pkg::ROM_MAX_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  badm_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output badm_pkg::rsp_type               rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [badm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [badm_pkg::CSR_DATA_W-1:0] csr_data
);

   logic             clearing;
   logic             fq_valid, fq_ready;
   badm_pkg::op_type fq_data;
   logic             qb_valid, qb_ready;
   badm_pkg::op_type qb_data;

   // Decode front
   badm_front #(
      .WORK_RAM_BYTES(WORK_RAM_BYTES),
      .SAVE_RAM_BYTES(SAVE_RAM_BYTES),
      .ROM_MAX_BYTES (ROM_MAX_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .clearing   (clearing),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .op_valid   (fq_valid),
      .op_ready   (fq_ready),
      .op_data    (fq_data)
   );

   // Byte op queue
   badm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(fq_valid),
      .push_ready(fq_ready),
      .push_data (fq_data),
      .pop_valid (qb_valid),
      .pop_ready (qb_ready),
      .pop_data  (qb_data)
   );

   // Memory back end
   badm_back #(
      .WORK_RAM_BYTES(WORK_RAM_BYTES),
      .SAVE_RAM_BYTES(SAVE_RAM_BYTES),
      .ROM_MAX_BYTES (ROM_MAX_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .clearing   (clearing),
      .op_valid   (qb_valid),
      .op_ready   (qb_ready),
      .op_data    (qb_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule
